FILE: sv/bpc_pkg.sv
// Shared types, codes and helpers for the button press classifier.
// Used by bpc_core and button_press_classifier; depends on nothing else.
package bpc_pkg;

    // Press mode, held one-hot inside the block.
    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_DEBOUNCE = 4'b0010,
        MODE_PRESSED  = 4'b0100,
        MODE_LONG     = 4'b1000
    } mode_t;

    // Mode codes as they appear on the result word.
    localparam logic [1:0] MODE_CODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_CODE_DEBOUNCE = 2'd1;
    localparam logic [1:0] MODE_CODE_PRESSED  = 2'd2;
    localparam logic [1:0] MODE_CODE_LONG     = 2'd3;

    // Event codes.
    localparam logic [1:0] EVENT_NONE  = 2'd0;
    localparam logic [1:0] EVENT_SHORT = 2'd1;
    localparam logic [1:0] EVENT_LONG  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] REG_SHORT_MIN = 2'd1;
    localparam logic [1:0] REG_LONG      = 2'd2;
    localparam logic [1:0] REG_MAX_HOLD  = 2'd3;

    // Reset values of the thresholds, in milliseconds.
    localparam logic [15:0] DEBOUNCE_RESET  = 16'd50;
    localparam logic [15:0] SHORT_MIN_RESET = 16'd50;
    localparam logic [15:0] LONG_RESET      = 16'd1000;
    localparam logic [15:0] MAX_HOLD_RESET  = 16'd3000;

    // Thresholds as written through the configuration port.
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] short_min_ms;
        logic [15:0] long_ms;
        logic [15:0] max_hold_ms;
    } cfg_t;

    // Classifier state carried from one word to the next.
    typedef struct packed {
        mode_t       mode;
        logic        last_level;
        logic [31:0] debounce_start;
        logic [31:0] press_start;
    } state_t;

    // Converts the one-hot mode into its result code.
    function automatic logic [1:0] mode_code(mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_IDLE:     code = MODE_CODE_IDLE;
            MODE_DEBOUNCE: code = MODE_CODE_DEBOUNCE;
            MODE_PRESSED:  code = MODE_CODE_PRESSED;
            MODE_LONG:     code = MODE_CODE_LONG;
            default:       code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/bpc_core.sv
// Combinational step of the classifier: one poll against the current state.
// Depends on bpc_pkg for the state, configuration and code definitions.
module bpc_core (
    input  logic             level,
    input  logic [31:0]      now_ms,
    input  bpc_pkg::cfg_t    cfg,
    input  bpc_pkg::state_t  state_cur,
    output bpc_pkg::state_t  state_next,
    output logic [1:0]       press_event
);

    logic        rising;
    logic        falling;
    logic [31:0] hold_time;
    logic [31:0] debounce_time;

    assign rising  = level && !state_cur.last_level;
    assign falling = !level && state_cur.last_level;

    // Time held since the press was confirmed; wrapping subtraction.
    assign hold_time = now_ms - state_cur.press_start;

    // A fresh rising edge restarts debounce at this poll, so its elapsed time is zero.
    assign debounce_time = rising ? 32'd0 : (now_ms - state_cur.debounce_start);

    always_comb begin
        state_next  = state_cur;
        press_event = bpc_pkg::EVENT_NONE;

        // Edge handling comes first.
        if (rising) begin
            state_next.mode           = bpc_pkg::MODE_DEBOUNCE;
            state_next.debounce_start = now_ms;
            state_next.last_level     = 1'b1;
        end else if (falling) begin
            if (state_cur.mode == bpc_pkg::MODE_PRESSED &&
                hold_time >= {16'd0, cfg.short_min_ms} &&
                hold_time <  {16'd0, cfg.long_ms}) begin
                press_event = bpc_pkg::EVENT_SHORT;
            end
            state_next.mode       = bpc_pkg::MODE_IDLE;
            state_next.last_level = 1'b0;
        end

        // Then the actions of the resulting mode run once.
        unique case (state_next.mode)
            bpc_pkg::MODE_DEBOUNCE: begin
                if (debounce_time >= {16'd0, cfg.debounce_ms}) begin
                    if (level) begin
                        state_next.mode        = bpc_pkg::MODE_PRESSED;
                        state_next.press_start = now_ms;
                    end else begin
                        state_next.mode = bpc_pkg::MODE_IDLE;
                    end
                end
            end
            bpc_pkg::MODE_PRESSED: begin
                if (hold_time >= {16'd0, cfg.long_ms}) begin
                    press_event     = bpc_pkg::EVENT_LONG;
                    state_next.mode = bpc_pkg::MODE_LONG;
                end
                if (hold_time >= {16'd0, cfg.max_hold_ms}) begin
                    state_next.mode = bpc_pkg::MODE_IDLE;
                end
            end
            bpc_pkg::MODE_LONG: begin
                if (hold_time >= {16'd0, cfg.max_hold_ms}) begin
                    state_next.mode = bpc_pkg::MODE_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: sv/button_press_classifier.sv
// Top level of the button press classifier: stream ports, registers, state.
// Depends on bpc_pkg and bpc_core.
//
// Usage: every poll of the button is one word on the slave channel, carrying
// the sampled level and a free-running millisecond timestamp. Each accepted
// word gives exactly one word on the master channel, in order: the press
// event (none, short or long) and the mode after that poll.
// The four thresholds are written through the cfg_ port while no word is in
// flight; a write takes effect at the clock edge where cfg_wr_en is high.
// A word passes two registers. The edge that accepts it loads the input
// register; the classification step then runs into the result register once
// that register is empty or being read, and m_tvalid rises as it is loaded.
// Throughput is one word per cycle while the receiver takes every result; the
// step that reads and updates the classifier state sets that figure.
// When the receiver stalls, the result register holds its word and the input
// register holds one more; s_tready falls only when both are full and
// m_tready is low.
// Synchronous reset loads the default thresholds, sets the mode to idle with
// the level released, clears both start times and empties both registers.
module button_press_classifier (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,

    // Poll words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [0] level, [32:1] now_ms, [39:33] zero

    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] press_event, [3:2] mode_now, [7:4] zero
);

    bpc_pkg::cfg_t   cfg_reg;
    bpc_pkg::state_t state_reg;
    bpc_pkg::state_t state_next;

    logic        in_valid_reg;
    logic        in_level_reg;
    logic [31:0] in_now_reg;

    logic        out_valid_reg;
    logic [1:0]  out_event_reg;
    logic [1:0]  out_mode_reg;

    logic [1:0]  event_next;
    logic        advance;
    logic        s_accept;

    // The step runs when a poll is waiting and the result register can take it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms  <= bpc_pkg::DEBOUNCE_RESET;
            cfg_reg.short_min_ms <= bpc_pkg::SHORT_MIN_RESET;
            cfg_reg.long_ms      <= bpc_pkg::LONG_RESET;
            cfg_reg.max_hold_ms  <= bpc_pkg::MAX_HOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bpc_pkg::REG_DEBOUNCE:  cfg_reg.debounce_ms  <= cfg_wr_data;
                bpc_pkg::REG_SHORT_MIN: cfg_reg.short_min_ms <= cfg_wr_data;
                bpc_pkg::REG_LONG:      cfg_reg.long_ms      <= cfg_wr_data;
                bpc_pkg::REG_MAX_HOLD:  cfg_reg.max_hold_ms  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[32:1];
        end
    end

    // Classification step.
    bpc_core u_core (
        .level       (in_level_reg),
        .now_ms      (in_now_reg),
        .cfg         (cfg_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .press_event (event_next)
    );

    // Classifier state, updated once per processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode           <= bpc_pkg::MODE_IDLE;
            state_reg.last_level     <= 1'b0;
            state_reg.debounce_start <= 32'd0;
            state_reg.press_start    <= 32'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= event_next;
            out_mode_reg  <= bpc_pkg::mode_code(state_next.mode);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_mode_reg, out_event_reg};

endmodule
